// ===== design/hcbd_pkg.sv =====
package hcbd_pkg;

  // Default sizes
  localparam int DEF_SIZE_BITS       = 32;
  localparam int DEF_LINE_COUNT_BITS = 14;

  // Configuration port
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int LINE_LEN_W  = 14;
  localparam logic [LINE_LEN_W-1:0] LINE_LEN_RESET = 14'd8192;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CHUNKED_MODE    = 3'd0,
    CFG_EXPECTED_LENGTH = 3'd1,
    CFG_LIMIT_ENABLE    = 3'd2,
    CFG_BODY_LIMIT      = 3'd3,
    CFG_MAX_LINE_LENGTH = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic                  chunked_mode;
    logic [31:0]           expected_length;
    logic                  limit_enable;
    logic [31:0]           body_limit;
    logic [LINE_LEN_W-1:0] max_line_length;
  } cfg_t;

  // Error codes
  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_MALFORMED = 2'd1,
    ERR_TOO_LARGE = 2'd2
  } err_t;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       body_done;
    err_t       error_code;
  } result_t;

  typedef enum logic [2:0] {
    PH_SIZE_LINE = 3'd0,
    PH_DATA      = 3'd1,
    PH_DATA_CR   = 3'd2,
    PH_DATA_LF   = 3'd3,
    PH_FINAL_CR  = 3'd4,
    PH_FINAL_LF  = 3'd5,
    PH_IDLE      = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    SUB_LEAD   = 2'd0,
    SUB_DIGITS = 2'd1,
    SUB_TRAIL  = 2'd2,
    SUB_EXT    = 2'd3
  } sub_t;

  // Characters of the size line
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  // Decode a hex digit: bit 4 is the hit flag, bits 3:0 the value
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

// ===== design/hcbd_cfg.sv =====
module hcbd_cfg
  import hcbd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  // Hold the register file; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.chunked_mode    <= 1'b0;
      cfg.expected_length <= '0;
      cfg.limit_enable    <= 1'b0;
      cfg.body_limit      <= '0;
      cfg.max_line_length <= LINE_LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CHUNKED_MODE:    cfg.chunked_mode    <= cfg_data[0];
        CFG_EXPECTED_LENGTH: cfg.expected_length <= cfg_data[31:0];
        CFG_LIMIT_ENABLE:    cfg.limit_enable    <= cfg_data[0];
        CFG_BODY_LIMIT:      cfg.body_limit      <= cfg_data[31:0];
        CFG_MAX_LINE_LENGTH: cfg.max_line_length <= cfg_data[LINE_LEN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== design/hcbd_parse.sv =====
module hcbd_parse
  import hcbd_pkg::*;
#(
  parameter int SIZE_BITS       = DEF_SIZE_BITS,
  parameter int LINE_COUNT_BITS = DEF_LINE_COUNT_BITS
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       step,
  input  logic [7:0] step_byte,
  output result_t    res
);

  localparam int TOT_W  = (SIZE_BITS > 32) ? SIZE_BITS : 32;
  localparam int LINE_W = (LINE_COUNT_BITS > LINE_LEN_W) ? LINE_COUNT_BITS : LINE_LEN_W;

  typedef struct packed {
    logic                 ok;
    sub_t                 sub;
    logic                 saw;
    logic [SIZE_BITS-1:0] size;
  } line_st_t;

  phase_t                     phase, phase_next;
  sub_t                       line_substate, line_substate_next;
  logic                       saw_digit, saw_digit_next;
  logic                       pending_cr, pending_cr_next;
  logic [LINE_COUNT_BITS-1:0] line_count, line_count_next;
  logic [SIZE_BITS-1:0]       chunk_size, chunk_size_next;
  logic [SIZE_BITS-1:0]       chunk_remaining, chunk_remaining_next;
  logic [SIZE_BITS-1:0]       total_count, total_count_next;

  logic [SIZE_BITS-1:0]       total_inc;
  logic [LINE_COUNT_BITS-1:0] line_inc;
  line_st_t                   st_cr, st_b;

  // Shift one hex digit into the size, refuse a value that outgrows the width
  function automatic line_st_t add_digit(input line_st_t s, input logic [3:0] d);
    line_st_t r;
    r = s;
    if (s.size[SIZE_BITS-1 -: 4] != 4'd0) begin
      r.ok = 1'b0;
    end else begin
      r.size = {s.size[SIZE_BITS-5:0], d};
      r.saw  = 1'b1;
    end
    return r;
  endfunction

  // Feed one ordinary line character through the trim/digit/extension walk
  function automatic line_st_t line_char(input line_st_t s, input logic [7:0] c);
    line_st_t   r;
    logic       blank;
    logic [4:0] hx;
    r     = s;
    blank = (c == CH_SP) || (c == CH_TAB);
    hx    = hex_decode(c);
    case (s.sub)
      SUB_LEAD: begin
        if (!blank) begin
          if (!hx[4]) begin
            r.ok = 1'b0;
          end else begin
            r.sub = SUB_DIGITS;
            r = add_digit(r, hx[3:0]);
          end
        end
      end
      SUB_DIGITS: begin
        if (hx[4]) begin
          r = add_digit(r, hx[3:0]);
        end else if (blank) begin
          r.sub = SUB_TRAIL;
        end else if (c == CH_SEMI) begin
          r.sub = SUB_EXT;
        end else begin
          r.ok = 1'b0;
        end
      end
      SUB_TRAIL: begin
        if (c == CH_SEMI) begin
          r.sub = SUB_EXT;
        end else if (!blank) begin
          r.ok = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Saturating counters
  assign total_inc = (total_count != '1) ? total_count + 1'b1 : total_count;
  assign line_inc  = (line_count != '1) ? line_count + 1'b1 : line_count;

  // A CR that is not followed by LF goes through as a line character
  always_comb begin
    st_cr = line_char({1'b1, line_substate, saw_digit, chunk_size}, CH_CR);
    if (!pending_cr) begin
      st_cr = {1'b1, line_substate, saw_digit, chunk_size};
    end
    st_b = line_char(st_cr, step_byte);
  end

  // Work out the result word and the next state for one byte
  always_comb begin
    phase_next           = phase;
    line_substate_next   = line_substate;
    saw_digit_next       = saw_digit;
    pending_cr_next      = pending_cr;
    line_count_next      = line_count;
    chunk_size_next      = chunk_size;
    chunk_remaining_next = chunk_remaining;
    total_count_next     = total_count;
    res                  = '0;

    if (phase == PH_IDLE) begin
      // discard
    end else if (!cfg.chunked_mode) begin
      if (TOT_W'(total_count) >= TOT_W'(cfg.expected_length)) begin
        res.body_done = 1'b1;
      end else begin
        res.payload_valid = 1'b1;
        res.payload_byte  = step_byte;
        total_count_next  = total_inc;
        if (TOT_W'(total_inc) >= TOT_W'(cfg.expected_length)) begin
          res.body_done = 1'b1;
        end
      end
      if (res.body_done) begin
        phase_next = PH_IDLE;
      end
    end else begin
      case (phase)
        PH_SIZE_LINE: begin
          line_count_next = line_inc;
          if (LINE_W'(line_inc) > LINE_W'(cfg.max_line_length)) begin
            res.error_code = ERR_MALFORMED;
          end else if (pending_cr && step_byte == CH_LF) begin
            if (!saw_digit) begin
              res.error_code = ERR_MALFORMED;
            end else begin
              chunk_remaining_next = chunk_size;
              phase_next = (chunk_size == '0) ? PH_FINAL_CR : PH_DATA;
              chunk_size_next    = '0;
              line_substate_next = SUB_LEAD;
              saw_digit_next     = 1'b0;
              pending_cr_next    = 1'b0;
              line_count_next    = '0;
            end
          end else if (!st_cr.ok || step_byte == CH_LF) begin
            res.error_code = ERR_MALFORMED;
          end else if (step_byte == CH_CR) begin
            line_substate_next = st_cr.sub;
            saw_digit_next     = st_cr.saw;
            chunk_size_next    = st_cr.size;
            pending_cr_next    = 1'b1;
          end else if (!st_b.ok) begin
            res.error_code = ERR_MALFORMED;
          end else begin
            line_substate_next = st_b.sub;
            saw_digit_next     = st_b.saw;
            chunk_size_next    = st_b.size;
            pending_cr_next    = 1'b0;
          end
        end
        PH_DATA: begin
          total_count_next = total_inc;
          if (cfg.limit_enable && TOT_W'(total_inc) > TOT_W'(cfg.body_limit)) begin
            res.error_code = ERR_TOO_LARGE;
          end else begin
            res.payload_valid = 1'b1;
            res.payload_byte  = step_byte;
            if (chunk_remaining != '0) begin
              chunk_remaining_next = chunk_remaining - 1'b1;
            end
            if (chunk_remaining_next == '0) begin
              phase_next = PH_DATA_CR;
            end
          end
        end
        PH_DATA_CR: begin
          if (step_byte != CH_CR) res.error_code = ERR_MALFORMED;
          else phase_next = PH_DATA_LF;
        end
        PH_DATA_LF: begin
          if (step_byte != CH_LF) begin
            res.error_code = ERR_MALFORMED;
          end else begin
            phase_next         = PH_SIZE_LINE;
            line_substate_next = SUB_LEAD;
            saw_digit_next     = 1'b0;
            pending_cr_next    = 1'b0;
            line_count_next    = '0;
          end
        end
        PH_FINAL_CR: begin
          if (step_byte != CH_CR) res.error_code = ERR_MALFORMED;
          else phase_next = PH_FINAL_LF;
        end
        default: begin
          if (step_byte != CH_LF) begin
            res.error_code = ERR_MALFORMED;
          end else begin
            res.body_done = 1'b1;
            phase_next    = PH_IDLE;
          end
        end
      endcase
      if (res.error_code != ERR_NONE) begin
        phase_next = PH_IDLE;
      end
    end
  end

  // Advance the parser state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SIZE_LINE;
      line_substate   <= SUB_LEAD;
      saw_digit       <= 1'b0;
      pending_cr      <= 1'b0;
      line_count      <= '0;
      chunk_size      <= '0;
      chunk_remaining <= '0;
      total_count     <= '0;
    end else if (step) begin
      phase           <= phase_next;
      line_substate   <= line_substate_next;
      saw_digit       <= saw_digit_next;
      pending_cr      <= pending_cr_next;
      line_count      <= line_count_next;
      chunk_size      <= chunk_size_next;
      chunk_remaining <= chunk_remaining_next;
      total_count     <= total_count_next;
    end
  end

  // A finished or failed body leaves the parser idle
  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    step && (res.body_done || res.error_code != ERR_NONE) |=> phase == PH_IDLE)
    else $error("parser not idle after done or error");

  // An idle parser gives all-zero words
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> res == '0)
    else $error("idle parser produced a non-zero word");

  // The last byte of a chunk moves on to the trailing CR
  a_chunk_end: assert property (@(posedge clk) disable iff (rst)
    step && cfg.chunked_mode && phase == PH_DATA && res.payload_valid
      && chunk_remaining == SIZE_BITS'(1) |=> phase == PH_DATA_CR)
    else $error("chunk end did not move to CR check");

  // A held CR belongs to the size line only
  a_cr_in_line: assert property (@(posedge clk) disable iff (rst)
    pending_cr && phase != PH_IDLE |-> phase == PH_SIZE_LINE)
    else $error("pending CR outside the size line");

endmodule

// ===== design/http_chunked_body_deframer_top.sv =====
// HTTP request body deframer: one raw body byte in per word, one result word out per byte
// (payload_valid/payload_byte, body_done, error_code). It takes a byte every cycle unless
// in_stall is high, which happens only while the receiver holds out_stall on a result word.
// A byte passes from the input register through the combinational parse step into the
// output register. Write the configuration registers right after reset and while no word is
// in flight. After body_done or an error every further byte yields an all-zero word until
// reset.
module http_chunked_body_deframer_top
  import hcbd_pkg::*;
#(
  parameter int SIZE_BITS       = DEF_SIZE_BITS,
  parameter int LINE_COUNT_BITS = DEF_LINE_COUNT_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   payload_valid,
  output logic [7:0]             payload_byte,
  output logic                   body_done,
  output logic [1:0]             error_code
);

  cfg_t       cfg;
  result_t    res;
  logic       in_reg_valid;
  logic [7:0] in_reg_byte;
  logic       out_free;
  logic       proc_fire;

  hcbd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hcbd_parse #(
    .SIZE_BITS       (SIZE_BITS),
    .LINE_COUNT_BITS (LINE_COUNT_BITS)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .step      (proc_fire),
    .step_byte (in_reg_byte),
    .res       (res)
  );

  // Pipeline control
  assign out_free  = !out_valid || !out_stall;
  assign proc_fire = in_reg_valid && out_free;
  assign in_stall  = in_reg_valid && !out_free;

  // Input register: load when empty or when its byte moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_reg_byte <= in_byte;
    end
  end

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= proc_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire) begin
      payload_valid <= res.payload_valid;
      payload_byte  <= res.payload_byte;
      body_done     <= res.body_done;
      error_code    <= res.error_code;
    end
  end

  // Input stalls only behind a held result word
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall && in_reg_valid)
    else $error("input stalled without a held result word");

endmodule

// ===== tb/sv/http_chunked_body_deframer_top_tb.sv =====
module http_chunked_body_deframer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hcbd_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned HOLD_CYCLES   = 250;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_X       = 8'h78;
  localparam logic [7:0] CH_Z       = 8'h7A;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [7:0]             in_byte = 8'h00;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   payload_valid;
  logic [7:0]             payload_byte;
  logic                   body_done;
  logic [1:0]             error_code;

  http_chunked_body_deframer_top uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .payload_valid (payload_valid),
    .payload_byte  (payload_byte),
    .body_done     (body_done),
    .error_code    (error_code)
  );

  always #2 clk = ~clk;

  // Deframer model: configuration copy and parse state
  cfg_t                  cfg_m;
  phase_t                ph;
  sub_t                  line_sub;
  logic                  digit_seen;
  logic                  cr_held;
  logic [LINE_LEN_W-1:0] line_len;
  logic [31:0]           size_acc;
  logic [31:0]           chunk_left;
  logic [31:0]           body_bytes;
  logic                  body_over;

  result_t     expected_words[$];
  logic [7:0]  frame_q[$];
  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  int unsigned burst_left = 0;
  int unsigned cycle_count = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_granted = 0;
  int unsigned hold_left = 0;
  int unsigned pat_left = 0;
  int unsigned pat_mode = 0;

  function automatic void clear_line_state();
    line_sub   = SUB_LEAD;
    digit_seen = 1'b0;
    cr_held    = 1'b0;
    line_len   = '0;
  endfunction

  // Shift one hex digit into the size; refuse once it would pass 32 bits
  function automatic logic push_digit(input logic [3:0] d);
    if (size_acc[31:28] != 4'd0) return 1'b0;
    size_acc   = {size_acc[27:0], d};
    digit_seen = 1'b1;
    return 1'b1;
  endfunction

  // Feed one ordinary size-line character; 0 on a bad line
  function automatic logic size_char(input logic [7:0] c);
    logic       blank;
    logic       is_hex;
    logic [3:0] d;
    blank  = (c == CH_SP) || (c == CH_TAB);
    is_hex = 1'b1;
    d      = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = 4'(c - 8'h37);
    end else begin
      is_hex = 1'b0;
    end
    case (line_sub)
      SUB_LEAD: begin
        if (blank) return 1'b1;
        if (!is_hex) return 1'b0;
        line_sub = SUB_DIGITS;
        return push_digit(d);
      end
      SUB_DIGITS: begin
        if (is_hex) return push_digit(d);
        if (blank) begin
          line_sub = SUB_TRAIL;
          return 1'b1;
        end
        if (c == CH_SEMI) begin
          line_sub = SUB_EXT;
          return 1'b1;
        end
        return 1'b0;
      end
      SUB_TRAIL: begin
        if (blank) return 1'b1;
        if (c == CH_SEMI) begin
          line_sub = SUB_EXT;
          return 1'b1;
        end
        return 1'b0;
      end
      default: return 1'b1;
    endcase
  endfunction

  // One byte of a chunk-size line; length check comes before the LF check
  function automatic err_t size_line_byte(input logic [7:0] b);
    if (line_len != '1) line_len++;
    if (line_len > cfg_m.max_line_length) return ERR_MALFORMED;
    if (cr_held) begin
      if (b == CH_LF) begin
        if (!digit_seen) return ERR_MALFORMED;
        chunk_left = size_acc;
        ph         = (size_acc == 32'd0) ? PH_FINAL_CR : PH_DATA;
        size_acc   = '0;
        clear_line_state();
        return ERR_NONE;
      end
      // a CR not followed by LF is just another line character
      cr_held = 1'b0;
      if (!size_char(CH_CR)) return ERR_MALFORMED;
    end
    if (b == CH_LF) return ERR_MALFORMED;
    if (b == CH_CR) begin
      cr_held = 1'b1;
      return ERR_NONE;
    end
    return size_char(b) ? ERR_NONE : ERR_MALFORMED;
  endfunction

  // Advance the model by one accepted byte and return the result word it gives
  function automatic result_t decode_byte(input logic [7:0] b);
    result_t r;
    r = '0;
    if (ph != PH_IDLE && !body_over) begin
      if (!cfg_m.chunked_mode) begin
        if (body_bytes >= cfg_m.expected_length) begin
          r.body_done = 1'b1;
        end else begin
          r.payload_valid = 1'b1;
          r.payload_byte  = b;
          if (body_bytes != '1) body_bytes++;
          if (body_bytes >= cfg_m.expected_length) r.body_done = 1'b1;
        end
        if (r.body_done) begin
          body_over = 1'b1;
          ph        = PH_IDLE;
        end
      end else begin
        case (ph)
          PH_SIZE_LINE: r.error_code = size_line_byte(b);
          PH_DATA: begin
            if (body_bytes != '1) body_bytes++;
            if (cfg_m.limit_enable && body_bytes > cfg_m.body_limit) begin
              r.error_code = ERR_TOO_LARGE;
            end else begin
              r.payload_valid = 1'b1;
              r.payload_byte  = b;
              if (chunk_left != 32'd0) chunk_left--;
              if (chunk_left == 32'd0) ph = PH_DATA_CR;
            end
          end
          PH_DATA_CR: begin
            if (b != CH_CR) r.error_code = ERR_MALFORMED;
            else ph = PH_DATA_LF;
          end
          PH_DATA_LF: begin
            if (b != CH_LF) begin
              r.error_code = ERR_MALFORMED;
            end else begin
              ph = PH_SIZE_LINE;
              clear_line_state();
            end
          end
          PH_FINAL_CR: begin
            if (b != CH_CR) r.error_code = ERR_MALFORMED;
            else ph = PH_FINAL_LF;
          end
          default: begin
            if (b != CH_LF) begin
              r.error_code = ERR_MALFORMED;
            end else begin
              r.body_done = 1'b1;
              body_over   = 1'b1;
              ph          = PH_IDLE;
            end
          end
        endcase
        if (r.error_code != ERR_NONE) ph = PH_IDLE;
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input logic upper);
    if (n < 4'd10) return CH_ZERO + 8'(n);
    return (upper ? CH_UPPER_A : CH_LOWER_A) + 8'(n) - 8'd10;
  endfunction

  // Append one byte to the frame being built
  function automatic void put_byte(input logic [7:0] b);
    frame_q = {frame_q, b};
  endfunction

  // Write one register and mirror it in the model; call only while drained
  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_CHUNKED_MODE:    cfg_m.chunked_mode    = value[0];
      CFG_EXPECTED_LENGTH: cfg_m.expected_length = value;
      CFG_LIMIT_ENABLE:    cfg_m.limit_enable    = value[0];
      CFG_BODY_LIMIT:      cfg_m.body_limit      = value;
      CFG_MAX_LINE_LENGTH: cfg_m.max_line_length = value[LINE_LEN_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Offer one byte in bursts with random gaps; predict on acceptance
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    result_t     want;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_stall);
    want = decode_byte(b);
    expected_words = {expected_words, want};
    bytes_sent++;
  endtask

  // Drop valid and wait until every expected word has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_words.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Send the queued frame bytes, optionally draining before byte pause_at
  task automatic send_frame(input int pause_at);
    int i;
    for (i = 0; i < frame_q.size(); i++) begin
      if (i == pause_at) wait_drained();
      send_byte(frame_q[i]);
    end
    frame_q.delete();
  endtask

  // Build a well-formed size line with random blanks, case, zeros and extension
  task automatic add_size_line(input int unsigned size);
    int unsigned nib;
    int unsigned n_ext;
    int          i;
    logic [7:0]  c;
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
      put_byte($urandom_range(0, 1) ? CH_SP : CH_TAB);
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
      put_byte(CH_ZERO);
    nib = 1;
    while (nib < 8 && (size >> (4 * nib)) != 0) nib++;
    for (i = nib - 1; i >= 0; i--)
      put_byte(hex_char(4'(size >> (4 * i)), 1'($urandom_range(0, 1))));
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
      put_byte($urandom_range(0, 1) ? CH_SP : CH_TAB);
    if ($urandom_range(0, 2) == 0) begin
      put_byte(CH_SEMI);
      n_ext = $urandom_range(0, 5);
      repeat (n_ext) begin
        c = 8'($urandom_range(0, 255));
        if (c == CH_CR || c == CH_LF) c = CH_X;
        put_byte(c);
      end
      // lone CR inside the extension
      if ($urandom_range(0, 3) == 0) begin
        put_byte(CH_CR);
        put_byte(CH_Z);
      end
    end
    put_byte(CH_CR);
    put_byte(CH_LF);
  endtask

  task automatic add_chunk(input int unsigned size);
    add_size_line(size);
    repeat (size) put_byte(8'($urandom_range(0, 255)));
    put_byte(CH_CR);
    put_byte(CH_LF);
  endtask

  task automatic stream_chunks(input int unsigned count);
    int unsigned stop_at;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      add_chunk(($urandom_range(0, 9) == 0) ? $urandom_range(25, 300) : $urandom_range(1, 24));
      send_frame(-1);
    end
  endtask

  // Length mode with the largest length: extremes of the byte pass through
  task automatic test_length_directed();
    write_reg(CFG_CHUNKED_MODE, 32'd0);
    write_reg(CFG_EXPECTED_LENGTH, 32'hFFFF_FFFF);
    frame_q = {8'h00, 8'hFF, 8'h80, 8'h7F};
    send_frame(-1);
    wait_drained();
  endtask

  // Leading zeros, trailing blanks, extension with a lone CR, one data byte
  task automatic test_chunk_directed();
    write_reg(CFG_CHUNKED_MODE, 32'd1);
    write_reg(CFG_MAX_LINE_LENGTH, 32'd16383);
    write_reg(CFG_LIMIT_ENABLE, 32'd0);
    write_reg(CFG_BODY_LIMIT, 32'd0);
    frame_q = {CH_ZERO, CH_ZERO, CH_ZERO, 8'h31, CH_SP, CH_TAB, CH_SEMI, 8'h65,
               CH_CR, CH_Z, CH_CR, CH_LF, 8'h5A, CH_CR, CH_LF};
    send_frame(-1);
    wait_drained();
  endtask

  task automatic test_chunk_stream();
    write_reg(CFG_MAX_LINE_LENGTH, 32'(LINE_LEN_RESET));
    stream_chunks(350);
    wait_drained();
  endtask

  // Long receiver hold while the sender keeps offering, then a mid-chunk pause
  task automatic test_backpressure();
    write_reg(CFG_LIMIT_ENABLE, 32'd1);
    write_reg(CFG_BODY_LIMIT, 32'hFFFF_FFFF);
    write_reg(CFG_MAX_LINE_LENGTH, 32'd16383);
    holds_asked++;
    stream_chunks(160);
    add_chunk(40);
    send_frame(20);
    wait_drained();
  endtask

  // Switch to length mode between chunks; counters carry over
  task automatic test_length_interlude();
    write_reg(CFG_CHUNKED_MODE, 32'd0);
    write_reg(CFG_EXPECTED_LENGTH, 32'hFFFF_FFFF);
    repeat (100) send_byte(8'($urandom_range(0, 255)));
    wait_drained();
    write_reg(CFG_CHUNKED_MODE, 32'd1);
  endtask

  // Short line limit that still fits every well-formed line
  task automatic test_tight_lines();
    write_reg(CFG_LIMIT_ENABLE, 32'd0);
    write_reg(CFG_BODY_LIMIT, 32'd0);
    write_reg(CFG_MAX_LINE_LENGTH, 32'($urandom_range(20, 40)));
    stream_chunks(350);
    wait_drained();
  endtask

  // End the body one way, then check that later bytes give empty words
  task automatic test_ending();
    int unsigned i;
    case ($urandom_range(0, 6))
      0: begin
        // zero-size chunk and final CRLF
        add_size_line(0);
        put_byte(CH_CR);
        put_byte(CH_LF);
        send_frame(-1);
      end
      1: begin
        // nine hex digits overflow the size
        for (i = 1; i <= 9; i++) put_byte(CH_ZERO + 8'(i));
        put_byte(CH_CR);
        put_byte(CH_LF);
        send_frame(-1);
      end
      2: begin
        case ($urandom_range(0, 5))
          0: frame_q = {8'($urandom_range(128, 255)), CH_CR, CH_LF};
          1: frame_q = {8'h35, CH_LF};
          2: frame_q = {8'h35, CH_CR, CH_X, CH_CR, CH_LF};
          3: frame_q = {CH_SP, CH_CR, CH_LF};
          4: frame_q = {CH_SP, CH_SEMI, CH_CR, CH_LF};
          default: begin
            // data not followed by CR
            add_size_line(3);
            repeat (3) put_byte(8'($urandom_range(0, 255)));
            put_byte(CH_X);
          end
        endcase
        send_frame(-1);
      end
      3: begin
        // line longer than the limit
        write_reg(CFG_MAX_LINE_LENGTH, $urandom_range(0, 1) ? 32'd2 : 32'($urandom_range(3, 8)));
        repeat (10) put_byte(CH_ZERO);
        put_byte(8'h31);
        put_byte(CH_CR);
        put_byte(CH_LF);
        send_frame(-1);
      end
      4: begin
        // total payload limit
        write_reg(CFG_LIMIT_ENABLE, 32'd1);
        write_reg(CFG_BODY_LIMIT,
                  $urandom_range(0, 1) ? 32'd0 : body_bytes + 32'($urandom_range(0, 40)));
        while (ph != PH_IDLE) begin
          add_chunk($urandom_range(1, 24));
          send_frame(-1);
        end
      end
      5: begin
        write_reg(CFG_CHUNKED_MODE, 32'd0);
        write_reg(CFG_EXPECTED_LENGTH, body_bytes + 32'($urandom_range(1, 30)));
        while (ph != PH_IDLE) send_byte(8'($urandom_range(0, 255)));
      end
      default: begin
        // zero length finishes on the first byte
        write_reg(CFG_CHUNKED_MODE, 32'd0);
        write_reg(CFG_EXPECTED_LENGTH, 32'd0);
      end
    endcase
    repeat (16) send_byte(8'($urandom_range(0, 255)));
    wait_drained();
  endtask

  // Receiver: long holds on request, otherwise a changing stall pattern
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (holds_granted != holds_asked) begin
      holds_granted = holds_asked;
      hold_left     = HOLD_CYCLES;
      out_stall    <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (pat_left == 0) begin
        pat_mode = $urandom_range(0, 3);
        pat_left = $urandom_range(10, 80);
      end
      pat_left--;
      case (pat_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Compare each accepted word with the oldest expectation
  always @(posedge clk) begin : check_words
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, got valid %b byte %0h done %b error %0d",
                 $time, payload_valid, payload_byte, body_done, error_code);
        mismatches++;
      end else begin
        want = expected_words.pop_front();
        check_field("payload_valid", 8'(want.payload_valid), 8'(payload_valid));
        check_field("payload_byte", want.payload_byte, payload_byte);
        check_field("body_done", 8'(want.body_done), 8'(body_done));
        check_field("error_code", 8'(want.error_code), 8'(error_code));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("http_chunked_body_deframer_top test failed");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    cfg_m.chunked_mode    = 1'b0;
    cfg_m.expected_length = '0;
    cfg_m.limit_enable    = 1'b0;
    cfg_m.body_limit      = '0;
    cfg_m.max_line_length = LINE_LEN_RESET;
    ph         = PH_SIZE_LINE;
    clear_line_state();
    size_acc   = '0;
    chunk_left = '0;
    body_bytes = '0;
    body_over  = 1'b0;

    test_length_directed();
    test_chunk_directed();
    test_chunk_stream();
    test_backpressure();
    test_length_interlude();
    test_tight_lines();
    test_ending();

    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("http_chunked_body_deframer_top test passed");
    end else begin
      $display("http_chunked_body_deframer_top test failed");
    end
    $finish;
  end

endmodule
